@@ src/olist_pkg.sv @@
// Package for the ordered list engine: beat structs, request and status codes,
// controller states and the per-cell control struct. Depends on nothing.
package olist_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  position;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] count;
  } out_beat_t;

  // Broadcast to every cell in the commit cycle.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

endpackage

@@ src/ordered_list_engine_unit.sv @@
// Top level of the ordered list engine; depends on olist_pkg and olist_cell.
// A request beat is captured in the request register and executes in the execute state;
// its result beat is registered in the output register once no earlier result beat
// stalls there. Compare, first-match ripple and shift all happen in the execute state;
// a new request is taken only when idle; a waiting result beat alone does not block it.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
module ordered_list_engine_unit
  import olist_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  // Only the low bits of the 32-bit value field take part in storing and
  // comparing, so cells are never wider than that field.
  localparam int KW    = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Positions compare against the count, so the compare width covers both
  // the 5-bit position field and the count register.
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t           state_r;
  state_t           state_nxt;
  in_beat_t         req_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_beat_t        out_beat_r;
  out_beat_t        out_beat_nxt;

  logic             commit;
  logic             full;
  logic             any_match;
  status_t          status;
  cell_ctl_t        ctl;
  logic [KW-1:0]    key;
  logic [CMP_W-1:0] req_pos;
  logic [CMP_W-1:0] cnt_cmp;
  logic [CMP_W-1:0] cell_pos;

  logic [KW-1:0]    words  [CAPACITY];
  logic             prefix [CAPACITY+1];

  assign key     = req_r.value[KW-1:0];
  assign req_pos = CMP_W'(req_r.position);
  assign cnt_cmp = CMP_W'(count_r);
  assign full    = (count_r == CAP_CNT);
  // Append is an insert at the current count.
  assign cell_pos = (req_r.action == ACT_APPEND) ? cnt_cmp : req_pos;

  // The chain of cells. Each cell sees its neighbors' words for shifting and
  // passes the running first-match flag to the cell above it.
  assign prefix[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KW-1:0] left_w;
    logic [KW-1:0] right_w;

    if (g == 0) begin : g_lo
      assign left_w = key;
    end else begin : g_lo
      assign left_w = words[g-1];
    end

    if (g == CAPACITY - 1) begin : g_hi
      assign right_w = words[g];
    end else begin : g_hi
      assign right_w = words[g+1];
    end

    olist_cell #(
      .IDX   (g),
      .KW    (KW),
      .CNT_W (CNT_W),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count_i  (count_r),
      .pos_i    (cell_pos),
      .key_i    (key),
      .left_i   (left_w),
      .right_i  (right_w),
      .prefix_i (prefix[g]),
      .prefix_o (prefix[g+1]),
      .word_o   (words[g])
    );
  end

  assign any_match = prefix[CAPACITY];

  // The request executes once the output register is free or being emptied
  // in the same cycle, so no result is ever overwritten.
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    status        = STAT_OK;
    ctl.ins_en    = 1'b0;
    ctl.rem_en    = 1'b0;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;

    case (req_r.action)
      ACT_APPEND: begin
        status     = full ? STAT_FULL : STAT_OK;
        ctl.ins_en = commit && !full;
      end
      ACT_INSERT: begin
        // An out-of-range position wins over a full list.
        if (req_pos > cnt_cmp) begin
          status = STAT_BAD_POS;
        end else if (full) begin
          status = STAT_FULL;
        end else begin
          status     = STAT_OK;
          ctl.ins_en = commit;
        end
      end
      ACT_REMOVE: begin
        status     = any_match ? STAT_OK : STAT_MISSING;
        ctl.rem_en = commit;
      end
      ACT_QUERY: begin
        status = any_match ? STAT_OK : STAT_MISSING;
      end
      default: begin
        status = STAT_MISSING;
      end
    endcase

    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.rem_en && any_match) begin
      count_nxt = count_r - CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt            = ST_IDLE;
          out_valid_nxt        = 1'b1;
          out_beat_nxt.status  = status;
          out_beat_nxt.count   = 5'(count_nxt);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_beat;
    end
    out_beat_r <= out_beat_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

@@ src/olist_cell.sv @@
// One storage cell of the ordered list: holds a single entry and shifts it up
// or down with its neighbors. Depends on olist_pkg.
module olist_cell
  import olist_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int KW    = 32,
  parameter int CNT_W = 5,
  parameter int CMP_W = 5
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count_i,
  input  logic [CMP_W-1:0] pos_i,
  input  logic [KW-1:0]    key_i,
  input  logic [KW-1:0]    left_i,
  input  logic [KW-1:0]    right_i,
  input  logic             prefix_i,
  output logic             prefix_o,
  output logic [KW-1:0]    word_o
);

  localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
  localparam logic [CMP_W-1:0] IDX_CMP = CMP_W'(IDX);

  logic [KW-1:0] word_r;
  logic [KW-1:0] word_nxt;
  logic          in_use;
  logic          hit;

  assign in_use   = IDX_CNT < count_i;
  assign hit      = in_use && (word_r == key_i);
  // The match flag ripples upward, so every cell at or after the first
  // matching entry sees it set.
  assign prefix_o = prefix_i | hit;
  assign word_o   = word_r;

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins_en) begin
      if (IDX_CMP == pos_i) begin
        word_nxt = key_i;
      end else if (IDX_CMP > pos_i) begin
        word_nxt = left_i;
      end
    end else if (ctl.rem_en && prefix_o) begin
      word_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

@@ src/olist_checker.sv @@
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on olist_pkg and on ordered_list_engine_unit for the bind.
module olist_checker
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  localparam logic [4:0] CAP5 = 5'(CAPACITY);
  localparam bit SMALL = CAPACITY < 32;

  // A stalled request beat holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_beat))
    else $error("request beat changed while stalled");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // The engine stalls intake after each accepted request while it executes it.
  a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in back-to-back cycles");

  // A full status means the list holds exactly its capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    SMALL && out_valid && out_beat.status == STAT_FULL |-> out_beat.count == CAP5)
    else $error("full status with count below capacity");

  // The count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    SMALL && out_valid |-> out_beat.count <= CAP5)
    else $error("count beyond capacity");

endmodule

bind ordered_list_engine_unit olist_checker #(
  .CAPACITY (CAPACITY)
) u_olist_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
